### sv/rjbf_pkg.sv
// rjbf_pkg: shared types and codes for the region join build filter
// row kinds, queue command kinds, configuration register indexes, back-end states
// no dependencies
`default_nettype none

package rjbf_pkg;

  // row kind carried on in_op
  localparam logic [1:0] OP_NATION   = 2'd0;
  localparam logic [1:0] OP_SUPPLIER = 2'd1;
  localparam logic [1:0] OP_CUSTOMER = 2'd2;
  localparam logic [1:0] OP_ORDER    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET_REGION = 2'd0;
  localparam logic [1:0] CFG_WINDOW_START  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_END    = 2'd2;

  // result map selector
  localparam logic MAP_SUPPLIER = 1'b0;
  localparam logic MAP_ORDER    = 1'b1;

  // nation code stored for a customer with no mapping
  localparam logic [5:0] NATION_NONE = 6'h3f;

  typedef enum logic [1:0] {
    CMD_MARK,
    CMD_SUPPLIER,
    CMD_CUSTOMER,
    CMD_ORDER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [30:0] key;
  } cmd_head_t;

  localparam int CMD_HEAD_W = $bits(cmd_head_t);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_t;

endpackage

`default_nettype wire

### sv/region_join_build_filter.sv
// region_join_build_filter: top level of the region-filtered join build side
// ties the front end, command queue and back end together; depends on rjbf_pkg
`default_nettype none

// Takes table rows (nation, supplier, customer, order) and emits supplier-to-nation
// and order-to-nation map entries. After reset the customer map is cleared one entry
// per cycle, with in_ready low; configuration writes are taken during that time. From
// then on one row is accepted per cycle unless out_ready stalls the output; the rate is
// set by the single port of the customer map, which each customer or order row uses once.
// A result is held in the command queue and then in the result register. Rows that
// can have no effect are absorbed by the front end without reaching the queue.
module region_join_build_filter #(
  parameter int NATION_CAPACITY   = 32,
  parameter int CUSTOMER_CAPACITY = 262144
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic signed [31:0] in_row_key,
  input  wire logic signed [31:0] in_row_region,
  input  wire logic signed [31:0] in_row_nation,
  input  wire logic signed [31:0] in_order_customer,
  input  wire logic signed [31:0] in_order_day,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_target_map,
  output logic [30:0]             out_entry_key,
  output logic signed [5:0]       out_entry_nation
);
  import rjbf_pkg::*;

  localparam int NIW   = $clog2(NATION_CAPACITY);
  localparam int CIW   = $clog2(CUSTOMER_CAPACITY);
  localparam int CMD_W = CMD_HEAD_W + NIW + CIW;

  logic            q_push, q_ready, q_pop, q_valid, clearing;
  cmd_head_t       f_head, b_head;
  logic [NIW-1:0]  f_nation, b_nation;
  logic [CIW-1:0]  f_cust, b_cust;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  rjbf_front #(
    .NATION_CAPACITY  (NATION_CAPACITY),
    .CUSTOMER_CAPACITY(CUSTOMER_CAPACITY)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_row_key       (in_row_key),
    .in_row_region    (in_row_region),
    .in_row_nation    (in_row_nation),
    .in_order_customer(in_order_customer),
    .in_order_day     (in_order_day),
    .q_ready          (q_ready),
    .hold             (clearing),
    .q_push           (q_push),
    .q_head           (f_head),
    .q_nation         (f_nation),
    .q_cust           (f_cust)
  );

  assign q_wdata = {f_head, f_nation, f_cust};

  rjbf_queue #(
    .DATA_W(CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  assign {b_head, b_nation, b_cust} = q_rdata;

  rjbf_back #(
    .NATION_CAPACITY  (NATION_CAPACITY),
    .CUSTOMER_CAPACITY(CUSTOMER_CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd_pop         (q_pop),
    .cmd_head        (b_head),
    .cmd_nation      (b_nation),
    .cmd_cust        (b_cust),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_target_map  (out_target_map),
    .out_entry_key   (out_entry_key),
    .out_entry_nation(out_entry_nation)
  );

endmodule

`default_nettype wire

### sv/rjbf_front.sv
// rjbf_front: configuration registers and row classification
// turns accepted rows into back-end commands and drops rows that can have no effect
// depends on rjbf_pkg
`default_nettype none

module rjbf_front #(
  parameter int NATION_CAPACITY   = 32,
  parameter int CUSTOMER_CAPACITY = 262144
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [1:0]                             cfg_index,
  input  wire logic [31:0]                            cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [1:0]                             in_op,
  input  wire logic signed [31:0]                     in_row_key,
  input  wire logic signed [31:0]                     in_row_region,
  input  wire logic signed [31:0]                     in_row_nation,
  input  wire logic signed [31:0]                     in_order_customer,
  input  wire logic signed [31:0]                     in_order_day,
  input  wire logic                                   q_ready,
  input  wire logic                                   hold,
  output logic                                        q_push,
  output rjbf_pkg::cmd_head_t                         q_head,
  output logic [$clog2(NATION_CAPACITY)-1:0]          q_nation,
  output logic [$clog2(CUSTOMER_CAPACITY)-1:0]        q_cust
);
  import rjbf_pkg::*;

  localparam int NIW = $clog2(NATION_CAPACITY);
  localparam int CIW = $clog2(CUSTOMER_CAPACITY);

  logic [7:0]         target_region_r, target_region_nxt;
  logic signed [31:0] win_start_r, win_start_nxt;
  logic signed [31:0] win_end_r, win_end_nxt;

  always_comb begin
    target_region_nxt = target_region_r;
    win_start_nxt     = win_start_r;
    win_end_nxt       = win_end_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_REGION: target_region_nxt = cfg_data[7:0];
        CFG_WINDOW_START:  win_start_nxt     = cfg_data;
        CFG_WINDOW_END:    win_end_nxt       = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_region_r <= '0;
      win_start_r     <= '0;
      win_end_r       <= '0;
    end else begin
      target_region_r <= target_region_nxt;
      win_start_r     <= win_start_nxt;
      win_end_r       <= win_end_nxt;
    end
  end

  // negative values read as huge unsigned numbers, so one compare covers both bounds
  logic key_nat_ok, row_nat_ok, key_cust_ok, ord_cust_ok;
  logic region_hit, key_nonneg, day_ok, keep;

  assign key_nat_ok  = $unsigned(in_row_key) < 32'(NATION_CAPACITY);
  assign row_nat_ok  = $unsigned(in_row_nation) < 32'(NATION_CAPACITY);
  assign key_cust_ok = $unsigned(in_row_key) < 32'(CUSTOMER_CAPACITY);
  assign ord_cust_ok = $unsigned(in_order_customer) < 32'(CUSTOMER_CAPACITY);
  assign region_hit  = $unsigned(in_row_region) == {24'd0, target_region_r};
  assign key_nonneg  = ~in_row_key[31];
  assign day_ok      = (in_order_day >= win_start_r) && (in_order_day < win_end_r);

  always_comb begin
    keep        = 1'b0;
    q_head.kind = CMD_MARK;
    q_head.key  = in_row_key[30:0];
    q_nation    = in_row_nation[NIW-1:0];
    q_cust      = in_row_key[CIW-1:0];
    case (in_op)
      OP_NATION: begin
        keep        = key_nat_ok && region_hit;
        q_head.kind = CMD_MARK;
        q_nation    = in_row_key[NIW-1:0];
      end
      OP_SUPPLIER: begin
        keep        = key_nonneg && row_nat_ok;
        q_head.kind = CMD_SUPPLIER;
      end
      OP_CUSTOMER: begin
        keep        = key_cust_ok && row_nat_ok;
        q_head.kind = CMD_CUSTOMER;
      end
      OP_ORDER: begin
        keep        = key_nonneg && day_ok && ord_cust_ok;
        q_head.kind = CMD_ORDER;
        q_cust      = in_order_customer[CIW-1:0];
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = q_ready && !hold;
  assign q_push   = in_valid && in_ready && keep;

endmodule

`default_nettype wire

### sv/rjbf_queue.sv
// rjbf_queue: two-entry command queue between the front and back ends
// generic data width, no package dependency
`default_nettype none

module rjbf_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   push_ready,
  input  wire logic              pop,
  output logic                   pop_valid,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### sv/rjbf_back.sv
// rjbf_back: nation bitmap, customer nation map and result register
// clears the customer map after reset, then runs one command per cycle
// unless out_ready stalls the result register; depends on rjbf_pkg
`default_nettype none

module rjbf_back #(
  parameter int NATION_CAPACITY   = 32,
  parameter int CUSTOMER_CAPACITY = 262144
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cmd_valid,
  output logic                                         cmd_pop,
  input  wire rjbf_pkg::cmd_head_t                     cmd_head,
  input  wire logic [$clog2(NATION_CAPACITY)-1:0]      cmd_nation,
  input  wire logic [$clog2(CUSTOMER_CAPACITY)-1:0]    cmd_cust,
  output logic                                         clearing,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic                                         out_target_map,
  output logic [30:0]                                  out_entry_key,
  output logic signed [5:0]                            out_entry_nation
);
  import rjbf_pkg::*;

  localparam int CIW = $clog2(CUSTOMER_CAPACITY);

  back_state_t state_r, state_nxt;
  logic [CIW-1:0] clr_addr_r, clr_addr_nxt;
  logic           clr_last;

  logic [NATION_CAPACITY-1:0] marks_r, marks_nxt;
  logic [5:0] cmap_mem [CUSTOMER_CAPACITY];
  logic [5:0] rd_data_r;

  logic       out_valid_r, out_valid_nxt;
  logic       out_map_r;
  logic [30:0] out_key_r;
  logic [5:0] out_nation_r;
  logic       out_use_mem_r;

  logic       marked, load, mem_we, mem_re;
  logic [CIW-1:0] mem_waddr;
  logic [5:0] mem_wdata;
  logic [5:0] nation6;

  assign clr_last = clr_addr_r == CIW'(CUSTOMER_CAPACITY - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    clearing     = 1'b0;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clearing     = 1'b1;
        clr_addr_nxt = clr_addr_r + CIW'(1);
      end
      ST_RUN:  clearing = 1'b0;
      default: clearing = 1'b1;
    endcase
  end

  // a command issues only when the result register is free or draining
  assign cmd_pop = cmd_valid && !clearing && (!out_valid_r || out_ready);
  assign marked  = marks_r[cmd_nation];
  assign nation6 = 6'(cmd_nation);

  always_comb begin
    marks_nxt = marks_r;
    load      = 1'b0;
    mem_re    = 1'b0;
    mem_we    = clearing;
    mem_waddr = clr_addr_r;
    mem_wdata = NATION_NONE;
    if (cmd_pop) begin
      case (cmd_head.kind)
        CMD_MARK:     marks_nxt[cmd_nation] = 1'b1;
        CMD_SUPPLIER: load = marked;
        CMD_CUSTOMER: begin
          mem_we    = marked;
          mem_waddr = cmd_cust;
          mem_wdata = nation6;
        end
        CMD_ORDER: begin
          load   = 1'b1;
          mem_re = 1'b1;
        end
        default: load = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_map_r     <= (cmd_head.kind == CMD_ORDER) ? MAP_ORDER : MAP_SUPPLIER;
      out_key_r     <= cmd_head.key;
      out_nation_r  <= nation6;
      out_use_mem_r <= cmd_head.kind == CMD_ORDER;
    end
  end

  // customer map: one write or one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= cmap_mem[cmd_cust];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_map   = out_map_r;
  assign out_entry_key    = out_key_r;
  assign out_entry_nation = out_use_mem_r ? rd_data_r : out_nation_r;

endmodule

`default_nettype wire
